// ===== rtl/vtcr_pkg.sv =====
`default_nettype none

package vtcr_pkg;

	// Block memory geometry; the memory size is a power of two so addresses wrap
	localparam int MEM_BYTES       = 8192;
	localparam int MAX_BLOCK_BYTES = 32;
	localparam int ADDR_W          = $clog2(MEM_BYTES);
	localparam int LOAD_ADDR_W     = 13;

	// Frame header capture
	localparam int HDR_DEPTH = 11;
	localparam int HDR_IDX_W = $clog2(HDR_DEPTH);

	// Job queue between front and back
	localparam int JOB_Q_DEPTH = 2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_UID        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_FORMAT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_ID      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_REFERENCE = 3'd5;

	// Request flags and command codes
	localparam int FLAG_ADDRESS_BIT   = 5;
	localparam int FLAG_INVENTORY_BIT = 2;
	localparam logic [7:0] OP_INVENTORY  = 8'h01;
	localparam logic [7:0] OP_READ_BLOCK = 8'h20;
	localparam logic [7:0] OP_SYS_INFO   = 8'h2B;

	// Response constants
	localparam logic [7:0] RESP_OK          = 8'h00;
	localparam logic [7:0] RESP_ERR_FLAGS   = 8'h01;
	localparam logic [7:0] RESP_ERR_RANGE   = 8'h10;
	localparam logic [7:0] SYS_INFO_FLAGS   = 8'h0F;

	typedef struct packed {
		logic [63:0] tag_uid;
		logic [7:0]  storage_format_id;
		logic [7:0]  family_id;
		logic [8:0]  block_total;
		logic [5:0]  block_bytes;
		logic [7:0]  chip_reference;
	} cfg_t;

	typedef struct packed {
		logic                   command;
		logic [7:0]             data_byte;
		logic                   frame_end;
		logic [LOAD_ADDR_W-1:0] load_address;
	} in_item_t;

	typedef struct packed {
		logic [7:0] resp_byte;
		logic       resp_last;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_INVENTORY,
		JOB_SYS_INFO,
		JOB_READ_OK,
		JOB_READ_ERR
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [5:0]        eff;
		logic [ADDR_W-1:0] base;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/vicinity_tag_command_responder.sv =====
`default_nettype none

// Channel   Handshake            Payload
// input     push / full          in_item  (command, data_byte, frame_end, load_address)
// result    empty / pop          out_item (resp_byte, resp_last)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Frame and load beats are taken one per cycle; a frame end is classified in the
// same cycle and queued as a job (two deep). Responses leave from one output
// register: header bytes one per cycle unless the receiver stalls, block data via
// request and data states (registered read of the block memory port). Loads stall
// while any job is queued or running; frame beats stall only on a full job
// queue. Reset is asynchronous, clears control state, and needs no memory sweep.
module vicinity_tag_command_responder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire vtcr_pkg::in_item_t              in_item,
	output logic                                 empty,
	input  wire logic                            pop,
	output vtcr_pkg::out_item_t                  out_item,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [vtcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [63:0]                     cfg_data
);
	import vtcr_pkg::*;

	cfg_t    cfg;
	job_t    fr_job;
	job_t    q_job;
	mem_wr_t mem_wr;
	logic    job_push;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	logic    back_busy;
	logic    jobs_pending;

	assign jobs_pending = !q_empty || back_busy;

	vtcr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vtcr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.push         (push),
		.full         (full),
		.in_item      (in_item),
		.job_full     (q_full),
		.jobs_pending (jobs_pending),
		.job_push     (job_push),
		.job          (fr_job),
		.mem_wr       (mem_wr)
	);

	vtcr_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (fr_job),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_job  (q_job),
		.q_empty (q_empty)
	);

	vtcr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_job    (q_job),
		.q_pop    (q_pop),
		.busy     (back_busy),
		.mem_wr   (mem_wr),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

`default_nettype wire

// ===== rtl/vtcr_cfg_regs.sv =====
`default_nettype none

module vtcr_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [vtcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [63:0]                      cfg_data,
	output vtcr_pkg::cfg_t                        cfg
);
	import vtcr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tag_uid           <= '0;
			cfg_q.storage_format_id <= '0;
			cfg_q.family_id         <= '0;
			cfg_q.block_total       <= 9'd64;
			cfg_q.block_bytes       <= 6'd4;
			cfg_q.chip_reference    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TAG_UID:        cfg_q.tag_uid           <= cfg_data;
				CFG_STORAGE_FORMAT: cfg_q.storage_format_id <= cfg_data[7:0];
				CFG_FAMILY_ID:      cfg_q.family_id         <= cfg_data[7:0];
				CFG_BLOCK_TOTAL:    cfg_q.block_total       <= cfg_data[8:0];
				CFG_BLOCK_BYTES:    cfg_q.block_bytes       <= cfg_data[5:0];
				CFG_CHIP_REFERENCE: cfg_q.chip_reference    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vtcr_front.sv =====
`default_nettype none

module vtcr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vtcr_pkg::cfg_t      cfg,
	input  wire logic                push,
	output logic                     full,
	input  wire vtcr_pkg::in_item_t  in_item,
	input  wire logic                job_full,
	input  wire logic                jobs_pending,
	output logic                     job_push,
	output vtcr_pkg::job_t           job,
	output vtcr_pkg::mem_wr_t        mem_wr
);
	import vtcr_pkg::*;

	logic [7:0] hdr_q [HDR_DEPTH];
	logic [7:0] len_q;

	logic [7:0]  hdr_n [HDR_DEPTH];
	logic [7:0]  len_n;
	logic [8:0]  len_inc;
	logic        accept;
	logic        frame_beat;
	logic        addressed;
	logic        inv_flag;
	logic        uid_mismatch;
	logic        uid_ok;
	logic [7:0]  blk;
	logic        rd_len_ok;
	logic [5:0]  eff;
	logic [13:0] prod;
	logic        job_ok;
	job_kind_t   kind;

	// Loads wait until every queued response has read the memory
	assign full       = job_full || (in_item.command && jobs_pending);
	assign accept     = push && !full;
	assign frame_beat = accept && !in_item.command;

	// Memory load port
	assign mem_wr.en   = accept && in_item.command &&
	                     (32'(in_item.load_address) < MEM_BYTES);
	assign mem_wr.addr = ADDR_W'(in_item.load_address);
	assign mem_wr.data = in_item.data_byte;

	// Header as it stands with the current beat included
	assign len_inc = {1'b0, len_q} + 9'd1;
	assign len_n   = (len_q == 8'hFF) ? 8'hFF : len_inc[7:0];

	always_comb begin
		for (int i = 0; i < HDR_DEPTH; i++) begin
			hdr_n[i] = (len_q == 8'(i)) ? in_item.data_byte : hdr_q[i];
		end
	end

	// Frame classification
	always_comb begin
		addressed    = hdr_n[0][FLAG_ADDRESS_BIT];
		inv_flag     = hdr_n[0][FLAG_INVENTORY_BIT];
		uid_mismatch = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (hdr_n[2+i] != cfg.tag_uid[8*i +: 8]) uid_mismatch = 1'b1;
		end
		uid_ok    = !(addressed && !inv_flag && (len_n >= 8'd10)) || !uid_mismatch;
		blk       = addressed ? hdr_n[10] : hdr_n[2];
		rd_len_ok = addressed ? (len_n >= 8'd11) : (len_n >= 8'd3);
		eff       = (cfg.block_bytes > 6'(MAX_BLOCK_BYTES)) ? 6'(MAX_BLOCK_BYTES)
		                                                    : cfg.block_bytes;
		prod      = 14'(blk) * 14'(eff);

		kind   = JOB_INVENTORY;
		job_ok = 1'b0;
		case (hdr_n[1])
			OP_INVENTORY: begin
				kind   = JOB_INVENTORY;
				job_ok = 1'b1;
			end
			OP_SYS_INFO: begin
				kind   = JOB_SYS_INFO;
				job_ok = 1'b1;
			end
			OP_READ_BLOCK: begin
				kind   = ({1'b0, blk} >= cfg.block_total) ? JOB_READ_ERR : JOB_READ_OK;
				job_ok = rd_len_ok;
			end
			default: ;
		endcase
		job_ok = job_ok && uid_ok && (len_n >= 8'd2);
	end

	assign job_push  = frame_beat && in_item.frame_end && job_ok;
	assign job.kind  = kind;
	assign job.eff   = eff;
	assign job.base  = ADDR_W'(prod);

	// Frame length; restarts after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (frame_beat) begin
			len_q <= in_item.frame_end ? 8'd0 : len_n;
		end
	end

	// Header bytes past the eleventh are dropped
	always_ff @(posedge clk) begin
		if (frame_beat && (len_q < 8'(HDR_DEPTH))) begin
			hdr_q[len_q[HDR_IDX_W-1:0]] <= in_item.data_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vtcr_job_fifo.sv =====
`default_nettype none

module vtcr_job_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire vtcr_pkg::job_t  wr_job,
	output logic                 q_full,
	input  wire logic            rd_en,
	output vtcr_pkg::job_t       rd_job,
	output logic                 q_empty
);
	import vtcr_pkg::*;

	localparam int PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

	job_t             slot_q [JOB_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(JOB_Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_job;
	end

endmodule

`default_nettype wire

// ===== rtl/vtcr_back.sv =====
`default_nettype none

module vtcr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vtcr_pkg::cfg_t     cfg,
	input  wire logic               q_empty,
	input  wire vtcr_pkg::job_t     q_job,
	output logic                    q_pop,
	output logic                    busy,
	input  wire vtcr_pkg::mem_wr_t  mem_wr,
	output logic                    empty,
	input  wire logic               pop,
	output vtcr_pkg::out_item_t     out_item
);
	import vtcr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_MREQ,
		ST_MDATA
	} state_t;

	logic [7:0] mem [MEM_BYTES];

	state_t            state_q;
	job_t              job_q;
	logic [3:0]        idx_q;
	logic [5:0]        cnt_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        rd_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic       out_free;
	logic       emit;
	logic [7:0] head_byte;
	logic       head_last;
	logic [2:0] uid_sel;
	logic [7:0] uid_byte;

	assign out_free = !out_valid_q || pop;
	assign emit     = ((state_q == ST_HEAD) || (state_q == ST_MDATA)) && out_free;
	assign empty    = !out_valid_q;
	assign out_item = out_q;
	assign busy     = (state_q != ST_IDLE);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	// Block memory: load writes, registered read at the current address
	always_ff @(posedge clk) begin
		if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
		rd_q <= mem[addr_q];
	end

	// Header bytes of each response
	assign uid_sel  = 3'(idx_q - 4'd2);
	assign uid_byte = cfg.tag_uid[{uid_sel, 3'b000} +: 8];

	always_comb begin
		head_byte = RESP_OK;
		head_last = 1'b0;
		case (job_q.kind)
			JOB_INVENTORY: begin
				case (idx_q)
					4'd0:    head_byte = RESP_OK;
					4'd1:    head_byte = cfg.storage_format_id;
					default: head_byte = uid_byte;
				endcase
				head_last = (idx_q == 4'd9);
			end
			JOB_SYS_INFO: begin
				case (idx_q)
					4'd0:    head_byte = RESP_OK;
					4'd1:    head_byte = SYS_INFO_FLAGS;
					4'd10:   head_byte = cfg.storage_format_id;
					4'd11:   head_byte = cfg.family_id;
					4'd12:   head_byte = 8'(cfg.block_total - 9'd1);
					4'd13:   head_byte = 8'(job_q.eff) - 8'd1;
					4'd14:   head_byte = cfg.chip_reference;
					default: head_byte = uid_byte;
				endcase
				head_last = (idx_q == 4'd14);
			end
			JOB_READ_ERR: begin
				head_byte = (idx_q == 4'd0) ? RESP_ERR_FLAGS : RESP_ERR_RANGE;
				head_last = (idx_q == 4'd1);
			end
			JOB_READ_OK: begin
				head_byte = RESP_OK;
				head_last = (job_q.eff == 6'd0);
			end
			default: ;
		endcase
	end

	// Response sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !pop);
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (out_free) begin
						if (head_last) begin
							state_q <= ST_IDLE;
						end else if (job_q.kind == JOB_READ_OK) begin
							state_q <= ST_MREQ;
						end
					end
				end
				ST_MREQ: begin
					state_q <= ST_MDATA;
				end
				ST_MDATA: begin
					if (out_free) begin
						state_q <= (cnt_q == 6'd1) ? ST_IDLE : ST_MREQ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Job context and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					job_q  <= q_job;
					idx_q  <= '0;
					cnt_q  <= q_job.eff;
					addr_q <= q_job.base;
				end
			end
			ST_HEAD: begin
				if (out_free) begin
					out_q.resp_byte <= head_byte;
					out_q.resp_last <= head_last;
					idx_q           <= idx_q + 4'd1;
				end
			end
			ST_MDATA: begin
				if (out_free) begin
					out_q.resp_byte <= rd_q;
					out_q.resp_last <= (cnt_q == 6'd1);
					cnt_q           <= cnt_q - 6'd1;
					addr_q          <= addr_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== bench/tag_response_checker.sv =====
`timescale 1ns / 100ps

// Watches the three channels of the tag responder, keeps its own image of the
// tag (registers, header capture, block memory) and checks every response beat
// against the oldest predicted one.
module tag_response_checker #(
	parameter logic CMD_LOAD = 1'b1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            full,
	input  wire vtcr_pkg::in_item_t              in_item,
	input  wire logic                            empty,
	input  wire logic                            pop,
	input  wire vtcr_pkg::out_item_t             out_item,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [vtcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [63:0]                     cfg_data,
	output int                                   fail_count,
	output int                                   due_count
);

	import vtcr_pkg::*;

	// Tag image
	cfg_t       tag_cfg;
	logic [7:0] hdr_bytes [HDR_DEPTH];
	logic [7:0] frame_len;
	logic [7:0] mem_image [MEM_BYTES];

	// Response beats still to come, oldest first
	out_item_t pending_resp_bytes [$];
	out_item_t resp_burst [$];
	int        mismatches;

	function automatic void put_byte(input logic [7:0] b);
		out_item_t r;
		r.resp_byte = b;
		r.resp_last = 1'b0;
		resp_burst.push_back(r);
	endfunction

	// Decode the captured frame and queue the response burst it causes
	function automatic void predict_response();
		logic [7:0] flags;
		logic [7:0] op;
		logic [7:0] blk;
		logic [5:0] eff;
		logic       addressed;
		int         last_idx;
		resp_burst.delete();
		if (frame_len < 8'd2)
			return;
		flags = hdr_bytes[0];
		op = hdr_bytes[1];
		addressed = flags[FLAG_ADDRESS_BIT];
		eff = (tag_cfg.block_bytes > 6'(MAX_BLOCK_BYTES)) ? 6'(MAX_BLOCK_BYTES)
			: tag_cfg.block_bytes;

		// UID match only when addressed, not inventory, and long enough
		if (addressed && !flags[FLAG_INVENTORY_BIT] && frame_len >= 8'd10) begin
			for (int i = 0; i < 8; i++)
				if (hdr_bytes[2+i] != tag_cfg.tag_uid[8*i +: 8])
					return;
		end

		case (op)
			OP_INVENTORY: begin
				put_byte(RESP_OK);
				put_byte(tag_cfg.storage_format_id);
				for (int i = 0; i < 8; i++)
					put_byte(tag_cfg.tag_uid[8*i +: 8]);
			end
			OP_READ_BLOCK: begin
				if (addressed) begin
					if (frame_len < 8'd11)
						return;
					blk = hdr_bytes[10];
				end else begin
					if (frame_len < 8'd3)
						return;
					blk = hdr_bytes[2];
				end
				if ({1'b0, blk} >= tag_cfg.block_total) begin
					put_byte(RESP_ERR_FLAGS);
					put_byte(RESP_ERR_RANGE);
				end else begin
					put_byte(RESP_OK);
					for (int i = 0; i < int'(eff); i++)
						put_byte(mem_image[(int'(blk) * int'(eff) + i) % MEM_BYTES]);
				end
			end
			OP_SYS_INFO: begin
				put_byte(RESP_OK);
				put_byte(SYS_INFO_FLAGS);
				for (int i = 0; i < 8; i++)
					put_byte(tag_cfg.tag_uid[8*i +: 8]);
				put_byte(tag_cfg.storage_format_id);
				put_byte(tag_cfg.family_id);
				put_byte(8'(int'(tag_cfg.block_total) - 1));
				put_byte(8'(int'(eff) - 1));
				put_byte(tag_cfg.chip_reference);
			end
			default: ;
		endcase

		last_idx = resp_burst.size() - 1;
		if (last_idx >= 0) begin
			resp_burst[last_idx].resp_last = 1'b1;
			foreach (resp_burst[i])
				pending_resp_bytes.push_back(resp_burst[i]);
		end
	endfunction

	always @(posedge clk) begin
		in_item_t  beat;
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			tag_cfg.tag_uid = '0;
			tag_cfg.storage_format_id = '0;
			tag_cfg.family_id = '0;
			tag_cfg.block_total = 9'd64;
			tag_cfg.block_bytes = 6'd4;
			tag_cfg.chip_reference = '0;
			frame_len = '0;
			pending_resp_bytes.delete();
		end else begin
			// Register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TAG_UID:        tag_cfg.tag_uid = cfg_data;
					CFG_STORAGE_FORMAT: tag_cfg.storage_format_id = cfg_data[7:0];
					CFG_FAMILY_ID:      tag_cfg.family_id = cfg_data[7:0];
					CFG_BLOCK_TOTAL:    tag_cfg.block_total = cfg_data[8:0];
					CFG_BLOCK_BYTES:    tag_cfg.block_bytes = cfg_data[5:0];
					CFG_CHIP_REFERENCE: tag_cfg.chip_reference = cfg_data[7:0];
					default: ;
				endcase
			end

			// Response beat out
			if (pop && !empty) begin
				got = out_item;
				if (pending_resp_bytes.size() == 0) begin
					mismatches++;
					$error("response beat with nothing expected: resp_byte %02h resp_last %0b",
						got.resp_byte, got.resp_last);
				end else begin
					want = pending_resp_bytes.pop_front();
					if (got.resp_byte !== want.resp_byte) begin
						mismatches++;
						$error("resp_byte: expected %02h, got %02h", want.resp_byte,
							got.resp_byte);
					end
					if (got.resp_last !== want.resp_last) begin
						mismatches++;
						$error("resp_last: expected %0b, got %0b", want.resp_last,
							got.resp_last);
					end
				end
			end

			// Request or load beat in
			if (push && !full) begin
				beat = in_item;
				if (beat.command == CMD_LOAD) begin
					if (int'(beat.load_address) < MEM_BYTES)
						mem_image[beat.load_address] = beat.data_byte;
				end else begin
					if (frame_len < 8'(HDR_DEPTH))
						hdr_bytes[frame_len] = beat.data_byte;
					if (frame_len != 8'hFF)
						frame_len++;
					if (beat.frame_end) begin
						predict_response();
						frame_len = '0;
					end
				end
			end
		end
		due_count <= pending_resp_bytes.size();
		fail_count <= mismatches;
	end

endmodule

// ===== bench/vicinity_tag_command_responder_tb.sv =====
`timescale 1ns / 100ps

module vicinity_tag_command_responder_tb;

	import vtcr_pkg::*;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam logic [7:0] FLAGS_PLAIN     = 8'h02;
	localparam logic [7:0] FLAGS_ADDRESSED = FLAGS_PLAIN | (8'd1 << FLAG_ADDRESS_BIT);

	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 55;
	localparam int SETTLE_CYCLES   = 32;
	localparam int TAIL_CYCLES     = 200;
	localparam int TIMEOUT_NS      = 50_000_000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	in_item_t              in_item = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [63:0]           cfg_data = '0;
	int                    fail_count;
	int                    due_count;

	// Sender and receiver idling, in percent of cycles
	int push_idle_pct = 0;
	int pop_stall_pct = 0;
	bit mix_loads = 1'b0;

	// Registers as last written, used to shape frames
	cfg_t cur_cfg = '{tag_uid: '0, storage_format_id: '0, family_id: '0,
		block_total: 9'd64, block_bytes: 6'd4, chip_reference: '0};

	logic [7:0] frame_bytes [$];

	// Memory bytes written so far; reads only ever touch these
	bit         loaded [MEM_BYTES];
	bit         frame_reads;
	logic [7:0] frame_blk;

	vicinity_tag_command_responder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tag_response_checker #(
		.CMD_LOAD (CMD_LOAD)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.empty      (empty),
		.pop        (pop),
		.out_item   (out_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

	// Receiver side: random stalls
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	function automatic in_item_t load_beat(input logic [LOAD_ADDR_W-1:0] addr);
		in_item_t b;
		b.command = CMD_LOAD;
		b.data_byte = 8'($urandom());
		b.frame_end = 1'($urandom());
		b.load_address = addr;
		return b;
	endfunction

	function automatic in_item_t noise_beat();
		in_item_t b;
		b.command = 1'($urandom());
		b.data_byte = 8'($urandom());
		b.frame_end = 1'($urandom());
		b.load_address = LOAD_ADDR_W'($urandom());
		return b;
	endfunction

	// Hold a beat on the input until it is taken
	task automatic push_beat(input in_item_t b);
		if (b.command == CMD_LOAD)
			loaded[b.load_address] = 1'b1;
		push <= 1'b1;
		in_item <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			in_item <= noise_beat();
			@(posedge clk);
		end
	endtask

	// Load whatever part of an in-range block has never been written
	task automatic cover_block(input logic [7:0] blk, output int beats);
		int eff;
		int a;
		beats = 0;
		eff = (cur_cfg.block_bytes > 6'(MAX_BLOCK_BYTES)) ? MAX_BLOCK_BYTES
			: int'(cur_cfg.block_bytes);
		if ({1'b0, blk} >= cur_cfg.block_total)
			return;
		for (int k = 0; k < eff; k++) begin
			a = (int'(blk) * eff + k) % MEM_BYTES;
			if (!loaded[a]) begin
				push_beat(load_beat(LOAD_ADDR_W'(a)));
				sender_gap();
				beats++;
			end
		end
	endtask

	task automatic send_frame(output int beats);
		in_item_t b;
		beats = 0;
		foreach (frame_bytes[i]) begin
			if (mix_loads && $urandom_range(99) < 6) begin
				push_beat(load_beat(LOAD_ADDR_W'($urandom())));
				sender_gap();
				beats++;
			end
			b.command = CMD_FRAME;
			b.data_byte = frame_bytes[i];
			b.frame_end = (i == frame_bytes.size() - 1);
			b.load_address = LOAD_ADDR_W'($urandom());
			push_beat(b);
			sender_gap();
			beats++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Random bits above the register width
	function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
		logic [63:0] r;
		logic [63:0] m;
		r = {$urandom(), $urandom()};
		m = (64'd1 << w) - 64'd1;
		return (r & ~m) | (v & m);
	endfunction

	task automatic apply_cfg(input cfg_t c);
		cur_cfg = c;
		write_reg(CFG_TAG_UID, c.tag_uid);
		write_reg(CFG_STORAGE_FORMAT, with_junk(64'(c.storage_format_id), 8));
		write_reg(CFG_FAMILY_ID, with_junk(64'(c.family_id), 8));
		write_reg(CFG_BLOCK_TOTAL, with_junk(64'(c.block_total), 9));
		write_reg(CFG_BLOCK_BYTES, with_junk(64'(c.block_bytes), 6));
		write_reg(CFG_CHIP_REFERENCE, with_junk(64'(c.chip_reference), 8));
		write_reg(CFG_SPARE, {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t phase_cfg(input int p);
		cfg_t c;
		c.tag_uid = {$urandom(), $urandom()};
		c.storage_format_id = 8'($urandom());
		c.family_id = 8'($urandom());
		c.chip_reference = 8'($urandom());
		c.block_total = 9'($urandom_range(256, 1));
		c.block_bytes = 6'($urandom_range(32, 1));
		case (p)
			1: begin
				c.block_total = 9'd256;
				c.block_bytes = 6'(MAX_BLOCK_BYTES);
			end
			2: begin
				c.tag_uid = '0;
				c.storage_format_id = '0;
				c.family_id = '0;
				c.chip_reference = '0;
				c.block_total = 9'd1;
				c.block_bytes = 6'd1;
			end
			// zero blocks, zero-byte blocks
			3: begin
				c.tag_uid = '1;
				c.storage_format_id = '1;
				c.family_id = '1;
				c.chip_reference = '1;
				c.block_total = '0;
				c.block_bytes = '0;
			end
			// block size above the cap saturates
			4: begin
				c.block_total = '1;
				c.block_bytes = '1;
			end
			5: begin
				c.block_total = 9'($urandom());
				c.block_bytes = 6'($urandom());
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pick_block();
		int r;
		int top_blk;
		r = $urandom_range(9);
		if (cur_cfg.block_total == 0 || r < 2)
			return 8'($urandom());
		top_blk = (cur_cfg.block_total > 9'd256) ? 255 : int'(cur_cfg.block_total) - 1;
		if (r == 2)
			return 8'(top_blk);
		if (r == 3)
			return 8'(cur_cfg.block_total);
		return 8'($urandom_range(top_blk));
	endfunction

	// Mostly well-formed requests with random content, some broken
	task automatic build_random_frame();
		int          pick;
		int          k;
		int          cut;
		logic [7:0]  flags;
		logic [7:0]  op;
		logic        addressed;
		logic [63:0] uid;
		frame_bytes.delete();
		frame_reads = 1'b0;
		pick = $urandom_range(99);
		flags = 8'($urandom());
		addressed = 1'($urandom());
		flags[FLAG_ADDRESS_BIT] = addressed;
		if (pick < 25)
			op = OP_INVENTORY;
		else if (pick < 60)
			op = OP_READ_BLOCK;
		else if (pick < 85)
			op = OP_SYS_INFO;
		else begin
			op = 8'($urandom());
			while (op == OP_INVENTORY || op == OP_READ_BLOCK || op == OP_SYS_INFO)
				op = 8'($urandom());
		end
		frame_bytes.push_back(flags);
		frame_bytes.push_back(op);
		if (addressed) begin
			uid = cur_cfg.tag_uid;
			if ($urandom_range(4) == 0) begin
				k = $urandom_range(7);
				uid[8*k +: 8] = uid[8*k +: 8] ^ 8'($urandom_range(255, 1));
			end
			for (int i = 0; i < 8; i++)
				frame_bytes.push_back(uid[8*i +: 8]);
		end
		if (op == OP_READ_BLOCK) begin
			frame_blk = pick_block();
			frame_reads = 1'b1;
			frame_bytes.push_back(frame_blk);
		end
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(8, 1))
				frame_bytes.push_back(8'($urandom()));
		// rare long frame, mostly long enough to saturate the length count
		if ($urandom_range(299) == 0)
			repeat ($urandom_range(262, 250))
				frame_bytes.push_back(8'($urandom()));
		if ($urandom_range(99) < 10) begin
			cut = $urandom_range(frame_bytes.size() - 1, 1);
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
		end
	endtask

	// Stop sending and wait for all responses, then let the block go quiet
	task automatic settle(input int cycles);
		push <= 1'b0;
		do
			@(posedge clk);
		while (due_count != 0);
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			0: begin push_idle_pct = 0;  pop_stall_pct <= 0;  end
			1: begin push_idle_pct = 88; pop_stall_pct <= 0;  end
			2: begin push_idle_pct = 0;  pop_stall_pct <= 88; end
			default: begin push_idle_pct = 7; pop_stall_pct <= 7; end
		endcase
	endtask

	initial begin
		int beats;
		int n;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under reset register values
		frame_bytes = '{FLAGS_PLAIN, OP_INVENTORY};
		send_frame(n);
		frame_bytes = '{FLAGS_PLAIN, OP_SYS_INFO};
		send_frame(n);
		cover_block(8'h00, n);
		frame_bytes = '{FLAGS_PLAIN, OP_READ_BLOCK, 8'h00};
		send_frame(n);
		// first block past the end
		frame_bytes = '{FLAGS_PLAIN, OP_READ_BLOCK, 8'h40};
		send_frame(n);
		// read without a block number
		frame_bytes = '{FLAGS_PLAIN, OP_READ_BLOCK};
		send_frame(n);
		// single-byte frame
		frame_bytes = '{8'hFF};
		send_frame(n);
		// unknown command
		frame_bytes = '{FLAGS_PLAIN, 8'hFF};
		send_frame(n);
		// addressed read matching the all-zero UID, block 255
		frame_bytes = '{FLAGS_ADDRESSED, OP_READ_BLOCK, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_frame(n);
		settle(SETTLE_CYCLES);

		// Random phases, each with its own registers and idling
		mix_loads = 1'b1;
		for (int p = 1; p <= PHASES; p++) begin
			set_idle((p - 1) % 4);
			apply_cfg(phase_cfg(p));
			beats = 0;
			while (beats < BEATS_PER_PHASE) begin
				build_random_frame();
				if (frame_reads) begin
					cover_block(frame_blk, n);
					beats += n;
				end
				send_frame(n);
				beats += n;
				// now and then hold off until the block has answered everything
				if ($urandom_range(99) < 4) begin
					push <= 1'b0;
					do
						@(posedge clk);
					while (due_count != 0);
				end
			end
			settle(SETTLE_CYCLES);
		end

		settle(TAIL_CYCLES);
		if (fail_count == 0 && due_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vtcr_pkg.sv
rtl/vtcr_cfg_regs.sv
rtl/vtcr_front.sv
rtl/vtcr_job_fifo.sv
rtl/vtcr_back.sv
rtl/vicinity_tag_command_responder.sv
bench/tag_response_checker.sv
bench/vicinity_tag_command_responder_tb.sv
